@@ sv/zpc2d_pkg.sv @@
`timescale 1ns / 1ps

package zpc2d_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_KERNEL = 7;

    localparam int CMD_W      = 2;
    localparam int COEF_IDX_W = 6;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int KSIZE_W    = 3;
    localparam int POS_W      = 10;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int FRAC_BITS  = 14;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd1024;
    localparam logic [KSIZE_W-1:0]    KSIZE_RESET  = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd2;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7fff_ffff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_COEF  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                  is_coef;
        logic                  emit;
        logic                  last;
        logic [POS_W-1:0]      row;
        logic [POS_W-1:0]      col;
        logic [COEF_IDX_W-1:0] cidx;
    } item_ctrl_t;

    // kernel entry that meets window tap (row offset i, column offset j)
    function automatic int coef_slot(input int i, input int j, input int k, input int hk);
        return (2 * hk - i) * k + (2 * hk - j);
    endfunction

endpackage

@@ sv/zpc2d_ram.sv @@
`timescale 1ns / 1ps

module zpc2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/zpc2d_front.sv @@
`timescale 1ns / 1ps

module zpc2d_front #(
    parameter int MAX_WIDTH  = zpc2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = zpc2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = zpc2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        eff_h,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]        half_k,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [zpc2d_pkg::CMD_W-1:0]            cmd,
    input  logic [zpc2d_pkg::COEF_IDX_W-1:0]       coef_index,
    input  logic signed [zpc2d_pkg::SAMPLE_W-1:0]  sample,
    output logic                                   s2_valid,
    output zpc2d_pkg::item_ctrl_t                  s2_ctrl,
    output logic signed [zpc2d_pkg::SAMPLE_W-1:0]  s2_data,
    output logic [MAX_KERNEL-1:0]                  s2_rmask,
    output logic [MAX_KERNEL-1:0]                  s2_cmask,
    output logic [MAX_KERNEL*MAX_KERNEL*zpc2d_pkg::SAMPLE_W-1:0] window,
    input  logic                                   take
);

    import zpc2d_pkg::*;

    localparam int K    = MAX_KERNEL;
    localparam int CW   = $clog2(MAX_WIDTH + MAX_KERNEL);
    localparam int RW   = $clog2(MAX_HEIGHT + MAX_KERNEL);
    localparam int CXW  = CW + 1;
    localparam int RXW  = RW + 1;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int MEMW = SAMPLE_W * (K - 1);
    localparam int COLW = SAMPLE_W * K;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic [CXW-1:0] col_x, w_x, hk_x, ocol_x;
    logic [RXW-1:0] row_x, h_x, hkr_x, orow_x;
    logic           col_in, row_in, emit, last, col_wrap, row_wrap;
    logic [K-1:0]   rmask, cmask;

    logic       accept, is_grid, load1, rd_en, fwd_hit, s1_move;
    logic [AW-1:0] rd_addr;

    logic                  s1_valid_reg;
    item_ctrl_t            s1_ctrl_reg;
    logic signed [SAMPLE_W-1:0] s1_data_reg;
    logic                  s1_we_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [K-1:0]          s1_rmask_reg, s1_cmask_reg;
    logic                  s1_fwd_reg;
    logic [MEMW-1:0]       fwd_data_reg;

    logic [MEMW-1:0] ram_rdata, mem_col, ram_wdata;
    logic            ram_we;
    logic [COLW-1:0] newcol;

    logic                  s2_valid_reg;
    item_ctrl_t            s2_ctrl_reg;
    logic signed [SAMPLE_W-1:0] s2_data_reg;
    logic [K-1:0]          s2_rmask_reg, s2_cmask_reg;
    logic [K*COLW-1:0]     win_reg, win_next;

    // scan position decode
    always_comb
    begin
        col_x    = {1'b0, col_reg};
        row_x    = {1'b0, row_reg};
        w_x      = CXW'(eff_w);
        h_x      = RXW'(eff_h);
        hk_x     = CXW'(half_k);
        hkr_x    = RXW'(half_k);
        col_in   = col_x < w_x;
        row_in   = row_x < h_x;
        ocol_x   = col_x - hk_x;
        orow_x   = row_x - hkr_x;
        emit     = (col_x >= hk_x) && (ocol_x < w_x) && (row_x >= hkr_x) && (orow_x < h_x);
        last     = (ocol_x == w_x - CXW'(1)) && (orow_x == h_x - RXW'(1));
        col_wrap = (col_x + CXW'(1)) >= (w_x + hk_x);
        row_wrap = (row_x + RXW'(1)) >= (h_x + hkr_x);
        for (int i = 0; i < K; i++)
        begin
            rmask[i] = (i <= 2 * int'(half_k)) && (row_x >= RXW'(i))
                       && ((row_x - RXW'(i)) < h_x);
            cmask[i] = (i <= 2 * int'(half_k)) && (col_x >= CXW'(i))
                       && ((col_x - CXW'(i)) < w_x);
        end
    end

    assign s1_move  = s1_valid_reg && (!s2_valid_reg || take);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;
    assign is_grid  = (cmd == CMD_PIXEL) || (cmd == CMD_FLUSH);
    assign load1    = accept && (cmd != CMD_NOP);
    assign rd_addr  = AW'(col_reg);
    assign rd_en    = accept && is_grid && col_in;
    // same column read while the previous beat writes it back
    assign fwd_hit  = rd_en && ram_we && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && is_grid)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load1)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_ctrl_reg.is_coef <= (cmd == CMD_COEF);
            s1_ctrl_reg.emit    <= emit;
            s1_ctrl_reg.last    <= last;
            s1_ctrl_reg.row     <= POS_W'(orow_x);
            s1_ctrl_reg.col     <= POS_W'(ocol_x);
            s1_ctrl_reg.cidx    <= coef_index;
            if (cmd == CMD_COEF)
            begin
                s1_data_reg <= sample;
            end
            else
            begin
                s1_data_reg <= (cmd == CMD_PIXEL && row_in && col_in) ? sample : '0;
            end
            s1_we_reg    <= col_in;
            s1_addr_reg  <= rd_addr;
            s1_rmask_reg <= rmask;
            s1_cmask_reg <= cmask;
            s1_fwd_reg   <= fwd_hit;
        end
        if (fwd_hit)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    zpc2d_ram #(
        .WIDTH (MEMW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // column entry keeps the newest rows in the low slots
    always_comb
    begin
        mem_col   = s1_fwd_reg ? fwd_data_reg : ram_rdata;
        ram_wdata = {mem_col[MEMW-SAMPLE_W-1:0], s1_data_reg};
        ram_we    = s1_move && !s1_ctrl_reg.is_coef && s1_we_reg;
        newcol[SAMPLE_W-1:0] = s1_data_reg;
        for (int m = 0; m < K - 1; m++)
        begin
            newcol[(m+1)*SAMPLE_W +: SAMPLE_W] = s1_we_reg ? mem_col[m*SAMPLE_W +: SAMPLE_W]
                                                           : '0;
        end
        win_next = win_reg;
        if (s1_move && !s1_ctrl_reg.is_coef)
        begin
            for (int j = K - 1; j > 0; j--)
            begin
                win_next[j*COLW +: COLW] = win_reg[(j-1)*COLW +: COLW];
            end
            win_next[COLW-1:0] = newcol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            win_reg <= win_next;
            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_data_reg  <= s1_data_reg;
            s2_rmask_reg <= s1_rmask_reg;
            s2_cmask_reg <= s1_cmask_reg;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_ctrl  = s2_ctrl_reg;
    assign s2_data  = s2_data_reg;
    assign s2_rmask = s2_rmask_reg;
    assign s2_cmask = s2_cmask_reg;
    assign window   = win_reg;

    a_fwd_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (s1_we_reg && !s1_ctrl_reg.is_coef))
        else $error("forwarded column on a beat that does not write the line store");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (col_x < w_x + hk_x) && (row_x < h_x + hkr_x))
        else $error("scan position outside the padded grid");

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit |=> (s1_valid_reg && s1_fwd_reg))
        else $error("forward hit lost before the beat reached stage one");

endmodule

@@ sv/zpc2d_mac.sv @@
`timescale 1ns / 1ps

module zpc2d_mac #(
    parameter int MAX_KERNEL = zpc2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]        kernel_k,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]        half_k,
    input  logic                                   s2_valid,
    input  zpc2d_pkg::item_ctrl_t                  s2_ctrl,
    input  logic signed [zpc2d_pkg::SAMPLE_W-1:0]  s2_data,
    input  logic [MAX_KERNEL-1:0]                  s2_rmask,
    input  logic [MAX_KERNEL-1:0]                  s2_cmask,
    input  logic [MAX_KERNEL*MAX_KERNEL*zpc2d_pkg::SAMPLE_W-1:0] window,
    output logic                                   take,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [zpc2d_pkg::OUT_W-1:0]     out_value,
    output logic [zpc2d_pkg::POS_W-1:0]            out_row,
    output logic [zpc2d_pkg::POS_W-1:0]            out_col,
    output logic                                   frame_last
);

    import zpc2d_pkg::*;

    localparam int K   = MAX_KERNEL;
    localparam int KSQ = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW = $clog2(KSQ);

    logic signed [SAMPLE_W-1:0] coef_reg [KSQ];
    logic signed [PROD_W-1:0]   prod_c [KSQ];
    logic signed [PROD_W-1:0]   prod_reg [KSQ];
    logic signed [ACC_W-1:0]    rowsum_c [K];
    logic signed [ACC_W-1:0]    rowsum_reg [K];
    logic signed [ACC_W-1:0]    total_c, total_reg, scaled;
    logic signed [OUT_W-1:0]    sat_c;

    logic       s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;
    item_ctrl_t s3_ctrl_reg, s4_ctrl_reg, s5_ctrl_reg, out_ctrl_reg;
    logic signed [OUT_W-1:0] out_value_reg;
    logic       move3, move4, move5, coef_wr;

    assign move5 = s5_valid_reg && (!out_valid_reg || out_ready);
    assign move4 = s4_valid_reg && (!s5_valid_reg || move5);
    assign move3 = s3_valid_reg && (!s4_valid_reg || move4);
    assign take  = s2_valid && (!s3_valid_reg || move3);
    assign coef_wr = take && s2_ctrl.is_coef && (int'(s2_ctrl.cidx) < KSQ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < KSQ; n++)
            begin
                coef_reg[n] <= '0;
            end
        end
        else if (coef_wr)
        begin
            coef_reg[CIW'(s2_ctrl.cidx)] <= s2_data;
        end
    end

    for (genvar j = 0; j < K; j++)
    begin : g_col
        for (genvar i = 0; i < K; i++)
        begin : g_row
            logic                       use_tap;
            logic [CIW-1:0]             sel;
            logic signed [SAMPLE_W-1:0] pix;
            logic signed [SAMPLE_W-1:0] cf;

            assign use_tap = s2_rmask[i] && s2_cmask[j];
            assign sel     = CIW'(coef_slot(i, j, int'(kernel_k), int'(half_k)));
            assign pix     = use_tap ? $signed(window[(j*K+i)*SAMPLE_W +: SAMPLE_W]) : '0;
            assign cf      = use_tap ? coef_reg[sel] : '0;
            assign prod_c[j*K+i] = pix * cf;
        end
    end

    always_comb
    begin
        for (int j = 0; j < K; j++)
        begin
            rowsum_c[j] = '0;
            for (int i = 0; i < K; i++)
            begin
                rowsum_c[j] = rowsum_c[j] + ACC_W'(prod_reg[j*K+i]);
            end
        end
        total_c = '0;
        for (int j = 0; j < K; j++)
        begin
            total_c = total_c + rowsum_reg[j];
        end
        // floor shift, then clamp to the 32-bit range
        scaled = total_reg >>> FRAC_BITS;
        if ((&scaled[ACC_W-1:OUT_W-1]) || !(|scaled[ACC_W-1:OUT_W-1]))
        begin
            sat_c = scaled[OUT_W-1:0];
        end
        else
        begin
            sat_c = scaled[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s3_valid_reg <= !s2_ctrl.is_coef && s2_ctrl.emit;
            end
            else if (move3)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (move3)
            begin
                s4_valid_reg <= 1'b1;
            end
            else if (move4)
            begin
                s4_valid_reg <= 1'b0;
            end
            if (move4)
            begin
                s5_valid_reg <= 1'b1;
            end
            else if (move5)
            begin
                s5_valid_reg <= 1'b0;
            end
            if (move5)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s3_ctrl_reg <= s2_ctrl;
            for (int n = 0; n < KSQ; n++)
            begin
                prod_reg[n] <= prod_c[n];
            end
        end
        if (move3)
        begin
            s4_ctrl_reg <= s3_ctrl_reg;
            for (int j = 0; j < K; j++)
            begin
                rowsum_reg[j] <= rowsum_c[j];
            end
        end
        if (move4)
        begin
            s5_ctrl_reg <= s4_ctrl_reg;
            total_reg   <= total_c;
        end
        if (move5)
        begin
            out_ctrl_reg  <= s5_ctrl_reg;
            out_value_reg <= sat_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_row    = out_ctrl_reg.row;
    assign out_col    = out_ctrl_reg.col;
    assign frame_last = out_ctrl_reg.last;

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s5_valid_reg))
        else $error("output beat appeared without a finished sum");

    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s2_ctrl.is_coef) |=> !s3_valid_reg)
        else $error("coefficient beat entered the multiply stage");

endmodule

@@ sv/zero_padded_conv2d_stream_top.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_ready   | cmd, coef_index, sample
// output   | out_valid / out_ready | out_value, out_row, out_col, frame_last
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat per cycle sustained while out_ready stays high
// line store entry per image column, read and written back per in-image grid beat
// reset clears scan position, coefficients, window and all pipeline valids
// output stall backs up through the pipeline stages before in_ready drops
// cfg_ready is always high; a register write restarts the frame scan
`timescale 1ns / 1ps

module zero_padded_conv2d_stream_top #(
    parameter int MAX_WIDTH  = zpc2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = zpc2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = zpc2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [zpc2d_pkg::CMD_W-1:0]           cmd,
    input  logic [zpc2d_pkg::COEF_IDX_W-1:0]      coef_index,
    input  logic signed [zpc2d_pkg::SAMPLE_W-1:0] sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [zpc2d_pkg::OUT_W-1:0]    out_value,
    output logic [zpc2d_pkg::POS_W-1:0]           out_row,
    output logic [zpc2d_pkg::POS_W-1:0]           out_col,
    output logic                                  frame_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [zpc2d_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [zpc2d_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import zpc2d_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int KW = $clog2(MAX_KERNEL + 1);

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [KSIZE_W-1:0]    ksize_reg;
    logic                  cfg_accept, restart;
    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [KW-1:0]         k_clamp, eff_k, half_k;

    item_ctrl_t                  s2_ctrl;
    logic                        s2_valid, take;
    logic signed [SAMPLE_W-1:0]  s2_data;
    logic [MAX_KERNEL-1:0]       s2_rmask, s2_cmask;
    logic [MAX_KERNEL*MAX_KERNEL*SAMPLE_W-1:0] window;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign restart    = cfg_accept && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT)
                                       || (cfg_index == REG_KERNEL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ksize_reg  <= KSIZE_RESET;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_KERNEL: ksize_reg  <= cfg_data[KSIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp registers to the supported ranges; even kernel sizes drop by one
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(height_reg);
        end
        k_clamp = (int'(ksize_reg) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ksize_reg);
        if (k_clamp == '0)
        begin
            eff_k = KW'(1);
        end
        else if (k_clamp[0])
        begin
            eff_k = k_clamp;
        end
        else
        begin
            eff_k = k_clamp - KW'(1);
        end
        half_k = eff_k >> 1;
    end

    zpc2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .half_k     (half_k),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .coef_index (coef_index),
        .sample     (sample),
        .s2_valid   (s2_valid),
        .s2_ctrl    (s2_ctrl),
        .s2_data    (s2_data),
        .s2_rmask   (s2_rmask),
        .s2_cmask   (s2_cmask),
        .window     (window),
        .take       (take)
    );

    zpc2d_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .kernel_k   (eff_k),
        .half_k     (half_k),
        .s2_valid   (s2_valid),
        .s2_ctrl    (s2_ctrl),
        .s2_data    (s2_data),
        .s2_rmask   (s2_rmask),
        .s2_cmask   (s2_cmask),
        .window     (window),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

endmodule
